/* rtl/rkwc_pkg.sv */
`default_nettype none
package rkwc_pkg;
  localparam int unsigned NumAnchors = 3;
  localparam int unsigned IdxW = $clog2(NumAnchors);
  localparam int unsigned MacW = 48;
  localparam int unsigned CovW = 18;
  localparam logic [CovW-1:0] KalQ = 18'd3277;
  localparam logic [20:0] KalR = 21'd589824;
  localparam logic [CovW-1:0] CovMax = 18'd262143;
  localparam logic signed [15:0] EstReset = -16'sd19200;
  localparam logic [CovW-1:0] CovReset = 18'd65536;
  localparam logic [31:0] Pos1Reset = 32'd179;
  localparam logic [31:0] Pos2Reset = 32'd11730944;
  localparam logic [2:0] RegMac0 = 3'd0;
  localparam logic [2:0] RegMac1 = 3'd1;
  localparam logic [2:0] RegMac2 = 3'd2;
  localparam logic [2:0] RegPos0 = 3'd3;
  localparam logic [2:0] RegPos1 = 3'd4;
  localparam logic [2:0] RegPos2 = 3'd5;

  typedef enum logic [3:0] {
    StIdle, StMatch, StCov, StDiv, StUpd, StCovN, StWgt, StAcc, StPx, StPdiv, StPdivY, StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic cov;
    logic div_start;
    logic upd;
    logic covn;
    logic wgt;
    logic acc;
    logic pdiv_start;
    logic pdiv_y;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic div_done;
    logic last_acc;
    logic all_seen;
    logic pdiv_done;
  } sts_t;

  function automatic logic [15:0] weight_lut(input logic [5:0] i);
    logic [15:0] w;
    case (i)
      6'd0: w = 256; 6'd1: w = 283; 6'd2: w = 313; 6'd3: w = 346; 6'd4: w = 382;
      6'd5: w = 422; 6'd6: w = 466; 6'd7: w = 516; 6'd8: w = 570; 6'd9: w = 630;
      6'd10: w = 696; 6'd11: w = 769; 6'd12: w = 850; 6'd13: w = 939; 6'd14: w = 1038;
      6'd15: w = 1147; 6'd16: w = 1268; 6'd17: w = 1401; 6'd18: w = 1549;
      6'd19: w = 1712; 6'd20: w = 1892; 6'd21: w = 2091; 6'd22: w = 2310;
      6'd23: w = 2553; 6'd24: w = 2822; 6'd25: w = 3119; 6'd26: w = 3447;
      6'd27: w = 3809; 6'd28: w = 4210; 6'd29: w = 4653; 6'd30: w = 5142;
      6'd31: w = 5683; 6'd32: w = 6280; 6'd33: w = 6941; 6'd34: w = 7671;
      6'd35: w = 8478; 6'd36: w = 9369; 6'd37: w = 10355; 6'd38: w = 11444;
      6'd39: w = 12647; 6'd40: w = 13977; 6'd41: w = 15447; 6'd42: w = 17072;
      6'd43: w = 18867; 6'd44: w = 20851; 6'd45: w = 23044; 6'd46: w = 25468;
      6'd47: w = 28146; 6'd48: w = 31107; 6'd49: w = 34378; 6'd50: w = 37994;
      default: w = 37994;
    endcase
    return w;
  endfunction
endpackage
`default_nettype wire

/* rtl/rssi_kalman_weighted_centroid_unit.sv */
`default_nettype none
// an accepted word is matched against the anchors; a miss goes straight to the result,
// a hit runs the gain divider and the estimate update, and, once every anchor is seen,
// the position divider for x and then for y; one word at a time: the next word is taken
// the cycle after the result is registered, and a stalled result holds off the next word
// reset: asynchronous active low; estimates -75 dBm, covariance 1.0, no anchor seen,
// anchor registers to their reset values
module rssi_kalman_weighted_centroid_unit import rkwc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MacW-1:0]   source_mac_i,
  input  wire logic signed [7:0] rssi_dbm_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   anchor_hit_o,
  output logic [1:0]             anchor_index_o,
  output logic signed [15:0]     filtered_rssi_o,
  output logic                   position_valid_o,
  output logic signed [15:0]     pos_x_o,
  output logic signed [15:0]     pos_y_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [5:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  logic [MacW-1:0] mac_q [NumAnchors];
  logic [31:0] pos_q [NumAnchors];
  cmd_t cmd;
  sts_t sts;
  logic wr;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  // registers sit every 8 bytes
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAnchors; i++) begin
        mac_q[i] <= '0;
        pos_q[i] <= '0;
      end
      pos_q[1] <= Pos1Reset;
      pos_q[2] <= Pos2Reset;
    end else if (wr) begin
      case (reg_idx)
        RegMac0: mac_q[0] <= pwdata[MacW-1:0];
        RegMac1: mac_q[1] <= pwdata[MacW-1:0];
        RegMac2: mac_q[2] <= pwdata[MacW-1:0];
        RegPos0: pos_q[0] <= pwdata[31:0];
        RegPos1: pos_q[1] <= pwdata[31:0];
        RegPos2: pos_q[2] <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMac0: prdata = {16'd0, mac_q[0]};
      RegMac1: prdata = {16'd0, mac_q[1]};
      RegMac2: prdata = {16'd0, mac_q[2]};
      RegPos0: prdata = {32'd0, pos_q[0]};
      RegPos1: prdata = {32'd0, pos_q[1]};
      RegPos2: prdata = {32'd0, pos_q[2]};
      default: prdata = '0;
    endcase
  end

  rkwc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rkwc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .mac_i(mac_q), .pos_i(pos_q),
    .source_mac_i, .rssi_dbm_i, .anchor_hit_o, .anchor_index_o, .filtered_rssi_o,
    .position_valid_o, .pos_x_o, .pos_y_o
  );
endmodule
`default_nettype wire

/* rtl/rkwc_ctrl.sv */
`default_nettype none
module rkwc_ctrl import rkwc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  state_e state_q, state_d;
  logic ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StMatch;
      StMatch: state_d = sts_i.hit ? StCov : StOut;
      StCov:   state_d = StDiv;
      StDiv:   if (sts_i.div_done) state_d = StUpd;
      StUpd:   state_d = StCovN;
      StCovN:  state_d = sts_i.all_seen ? StWgt : StOut;
      StWgt:   state_d = StAcc;
      StAcc:   state_d = sts_i.last_acc ? StPx : StWgt;
      StPx:    state_d = StPdiv;
      StPdiv:  if (sts_i.pdiv_done) state_d = StPdivY;
      StPdivY: if (sts_i.pdiv_done) state_d = StOut;
      StOut:   if (!ovalid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != StIdle);
    ovalid_d = ovalid_q && out_stall_i;
    case (state_q)
      StIdle:  cmd_o.load = in_valid_i;
      StMatch: cmd_o.match = 1'b1;
      StCov:   begin cmd_o.cov = 1'b1; cmd_o.div_start = 1'b1; end
      StUpd:   cmd_o.upd = 1'b1;
      StCovN:  cmd_o.covn = 1'b1;
      StWgt:   cmd_o.wgt = 1'b1;
      StAcc:   cmd_o.acc = 1'b1;
      StPx:    cmd_o.pdiv_start = 1'b1;
      // x done: start y right away
      StPdiv:  begin
        cmd_o.pdiv_start = sts_i.pdiv_done;
        cmd_o.pdiv_y = sts_i.pdiv_done;
      end
      StPdivY: cmd_o.pdiv_y = 1'b1;
      StOut:   if (!ovalid_q || !out_stall_i) begin
        cmd_o.out_load = 1'b1;
        ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/rkwc_datapath.sv */
`default_nettype none
module rkwc_datapath import rkwc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [MacW-1:0]     mac_i [NumAnchors],
  input  wire logic [31:0]         pos_i [NumAnchors],
  input  wire logic [MacW-1:0]     source_mac_i,
  input  wire logic signed [7:0]   rssi_dbm_i,
  output logic                     anchor_hit_o,
  output logic [1:0]               anchor_index_o,
  output logic signed [15:0]       filtered_rssi_o,
  output logic                     position_valid_o,
  output logic signed [15:0]       pos_x_o,
  output logic signed [15:0]       pos_y_o
);
  logic signed [15:0] est_q [NumAnchors];
  logic [CovW-1:0]    cov_q [NumAnchors];
  logic [NumAnchors-1:0] seen_q;
  logic [MacW-1:0] smac_q;
  logic signed [7:0] meas_q;
  logic hit_q;
  logic [IdxW-1:0] idx_q;
  logic [CovW-1:0] p_q;
  // kalman gain divider: 34-bit dividend, 21-bit divisor
  logic [33:0] kq_q;
  logic [21:0] krem_q;
  logic [20:0] kden_q;
  logic [5:0]  kcnt_q;
  logic [16:0] k_q;
  // position accumulation
  logic [IdxW-1:0] aidx_q;
  logic [15:0] w_q;
  logic signed [15:0] wx_q, wy_q;
  logic signed [39:0] vx_q, vy_q;
  logic [19:0] ws_q;
  // signed-magnitude rounding divider, 40-bit numerator
  logic [40:0] pnum_q;
  logic [20:0] prem_q;
  logic [5:0]  pcnt_q;
  logic pneg_q, pbusy_q;
  logic signed [15:0] px_q;
  logic o_hit_q, o_pv_q;
  logic [1:0] o_idx_q;
  logic signed [15:0] o_est_q, o_x_q, o_y_q;

  logic [IdxW-1:0] hidx;
  logic hfound;
  always_comb begin
    hfound = 1'b0;
    hidx = '0;
    for (int i = NumAnchors - 1; i >= 0; i--) begin
      if (mac_i[i] == smac_q) begin
        hfound = 1'b1;
        hidx = IdxW'(i);
      end
    end
  end

  logic [CovW:0] psum;
  assign psum = {1'b0, cov_q[idx_q]} + {1'b0, KalQ};

  logic [21:0] ktrial;
  assign ktrial = {krem_q[20:0], kq_q[33]} - {1'b0, kden_q};

  // estimate update
  logic signed [17:0] diff;
  logic signed [34:0] prod;
  logic [34:0] pmag;
  logic [18:0] qmag;
  logic signed [19:0] qs;
  logic signed [20:0] nest;
  logic signed [15:0] nest_sat;
  always_comb begin
    diff = 18'(signed'({meas_q, 8'd0})) - 18'(est_q[idx_q]);
    prod = signed'({18'd0, k_q}) * 35'(diff);
    pmag = prod[34] ? 35'(-prod) : prod;
    qmag = 19'((pmag + 35'd32768) >> 16);
    qs = prod[34] ? -20'(signed'({1'b0, qmag})) : 20'(signed'({1'b0, qmag}));
    nest = 21'(est_q[idx_q]) + 21'(qs);
    if (nest > 21'sd32767) nest_sat = 16'sd32767;
    else if (nest < -21'sd32768) nest_sat = -16'sd32768;
    else nest_sat = nest[15:0];
  end

  logic [35:0] pn_full;
  logic [19:0] pn;
  assign pn_full = ({19'd0, 17'(17'h10000 - k_q)} * {18'd0, p_q}) + 36'd32768;
  assign pn = pn_full[35:16];

  // weight
  logic signed [15:0] ce;
  logic [15:0] off;
  logic [6:0] widx;
  always_comb begin
    ce = est_q[aidx_q];
    if (ce < -16'sd23040) ce = -16'sd23040;
    if (ce > -16'sd10240) ce = -16'sd10240;
    off = 16'(ce + 16'sd23040 + 16'sd128);
    widx = off[14:8];
  end

  logic [40:0] ptrial_in;
  logic [21:0] ptrial;
  assign ptrial = {prem_q, pnum_q[40]} - {2'd0, ws_q};
  logic [39:0] vsel;
  logic [39:0] vmag;
  always_comb begin
    vsel = cmd_i.pdiv_y ? vy_q : vx_q;
    vmag = vsel[39] ? 40'(-signed'(vsel)) : vsel;
    ptrial_in = {1'b0, vmag} + {22'd0, ws_q[19:1]};
  end
  logic signed [16:0] pres;
  logic signed [15:0] pres_sat;
  always_comb begin
    pres = pneg_q ? -17'(signed'({1'b0, pnum_q[15:0]})) : 17'(signed'({1'b0, pnum_q[15:0]}));
    if (pnum_q[40:16] != '0) pres_sat = pneg_q ? -16'sd32768 : 16'sd32767;
    else if (pres > 17'sd32767) pres_sat = 16'sd32767;
    else if (pres < -17'sd32768) pres_sat = -16'sd32768;
    else pres_sat = pres[15:0];
  end

  assign sts_o.hit = hfound;
  assign sts_o.div_done = (kcnt_q == '0);
  assign sts_o.last_acc = (aidx_q == IdxW'(NumAnchors - 1));
  assign sts_o.all_seen = &seen_q;
  assign sts_o.pdiv_done = !pbusy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAnchors; i++) begin
        est_q[i] <= EstReset;
        cov_q[i] <= CovReset;
      end
      seen_q <= '0;
      kcnt_q <= '0;
      pbusy_q <= 1'b0;
    end else begin
      if (cmd_i.cov) begin
        kcnt_q <= 6'd34;
      end else if (kcnt_q != '0) begin
        kcnt_q <= kcnt_q - 6'd1;
      end
      if (cmd_i.pdiv_start) pbusy_q <= 1'b1;
      else if (pcnt_q == 6'd1) pbusy_q <= 1'b0;
      if (cmd_i.upd) begin
        est_q[idx_q] <= nest_sat;
        seen_q[idx_q] <= 1'b1;
      end
      if (cmd_i.covn) cov_q[idx_q] <= (pn > 20'(CovMax)) ? CovMax : pn[CovW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smac_q <= source_mac_i;
      meas_q <= rssi_dbm_i;
    end
    if (cmd_i.match) begin
      hit_q <= hfound;
      idx_q <= hidx;
    end
    if (cmd_i.cov) begin
      p_q <= psum[CovW] ? CovMax : psum[CovW-1:0];
      kq_q <= {(psum[CovW] ? CovMax : psum[CovW-1:0]), 16'd0};
      kden_q <= 21'((psum[CovW] ? {3'd0, CovMax} : {2'd0, psum}) + KalR);
      krem_q <= '0;
    end else if (kcnt_q != '0) begin
      if (!ktrial[21]) begin
        krem_q <= ktrial;
        kq_q <= {kq_q[32:0], 1'b1};
      end else begin
        krem_q <= {krem_q[20:0], kq_q[33]};
        kq_q <= {kq_q[32:0], 1'b0};
      end
      if (kcnt_q == 6'd1) k_q <= 17'(!ktrial[21] ? {kq_q[32:0], 1'b1} : {kq_q[32:0], 1'b0});
    end
    if (cmd_i.covn) begin
      aidx_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      ws_q <= '0;
    end
    if (cmd_i.wgt) begin
      w_q <= weight_lut(widx[5:0]);
      wx_q <= pos_i[aidx_q][31:16];
      wy_q <= pos_i[aidx_q][15:0];
    end
    if (cmd_i.acc) begin
      vx_q <= vx_q + 40'(signed'({1'b0, w_q}) * 17'(wx_q));
      vy_q <= vy_q + 40'(signed'({1'b0, w_q}) * 17'(wy_q));
      ws_q <= ws_q + 20'(w_q);
      aidx_q <= aidx_q + IdxW'(1);
    end
    if (cmd_i.pdiv_start) begin
      pnum_q <= ptrial_in;
      pneg_q <= vsel[39];
      prem_q <= '0;
      pcnt_q <= 6'd41;
    end else if (pbusy_q) begin
      if (!ptrial[21]) begin
        prem_q <= ptrial[20:0];
        pnum_q <= {pnum_q[39:0], 1'b1};
      end else begin
        prem_q <= {prem_q[19:0], pnum_q[40]};
        pnum_q <= {pnum_q[39:0], 1'b0};
      end
      pcnt_q <= pcnt_q - 6'd1;
    end
    // x quotient is final when the y division starts
    if (cmd_i.pdiv_start && cmd_i.pdiv_y) px_q <= pres_sat;
    if (cmd_i.out_load) begin
      o_hit_q <= hit_q;
      o_idx_q <= hit_q ? 2'(idx_q) : 2'd0;
      o_est_q <= hit_q ? est_q[idx_q] : 16'sd0;
      o_pv_q <= hit_q && (&seen_q);
      o_x_q <= (hit_q && (&seen_q)) ? px_q : 16'sd0;
      o_y_q <= (hit_q && (&seen_q)) ? pres_sat : 16'sd0;
    end
  end

  assign anchor_hit_o = o_hit_q;
  assign anchor_index_o = o_idx_q;
  assign filtered_rssi_o = o_est_q;
  assign position_valid_o = o_pv_q;
  assign pos_x_o = o_x_q;
  assign pos_y_o = o_y_q;
endmodule
`default_nettype wire
